>>> hw/rtl/nearest_scale_gray_quantizer_top_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the scaler/quantizer checker
// Concurrent assertion shorthands with a common clock and reset.
// ----------------------------------------------------------------------------
`ifndef NEAREST_SCALE_GRAY_QUANTIZER_TOP_ASSERT_SVH
`define NEAREST_SCALE_GRAY_QUANTIZER_TOP_ASSERT_SVH

// same-cycle implication
`define NSGQ_ASSERT_SAME(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define NSGQ_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> hw/rtl/nsgq_pkg.sv
// ----------------------------------------------------------------------------
// nsgq_pkg
// Shared constants, types and the gray-level quantizer function.
// ----------------------------------------------------------------------------
package nsgq_pkg;

  // frame store geometry
  localparam int SRC_WIDTH_MAX  = 512;
  localparam int SRC_HEIGHT_MAX = 512;
  localparam int STORE_DEPTH    = SRC_WIDTH_MAX * SRC_HEIGHT_MAX;
  localparam int STORE_AW       = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;

  // field widths
  localparam int DIM_W  = 10;
  localparam int LVL_W  = 9;
  localparam int PIX_W  = 8;
  localparam int PROD_W = 2 * DIM_W;
  localparam int CFG_IW = 3;

  // divider: quotient always fits DIM_W bits, one bit per step
  localparam int DIV_STEPS = DIM_W;
  localparam int CNT_W     = $clog2(DIV_STEPS);

  // result status codes
  localparam logic [1:0] ST_READ  = 2'd0;
  localparam logic [1:0] ST_WRITE = 2'd1;
  localparam logic [1:0] ST_RANGE = 2'd2;

  // operation codes
  localparam logic OP_WRITE = 1'b0;
  localparam logic OP_READ  = 1'b1;

  // configuration register indexes
  typedef enum logic [CFG_IW-1:0] {
    CFG_SRC_WIDTH   = 3'd0,
    CFG_SRC_HEIGHT  = 3'd1,
    CFG_DST_WIDTH   = 3'd2,
    CFG_DST_HEIGHT  = 3'd3,
    CFG_GRAY_LEVELS = 3'd4
  } cfg_idx_t;

  // divider axis
  localparam logic AXIS_ROW = 1'b0;
  localparam logic AXIS_COL = 1'b1;

  // controller -> datapath commands
  typedef struct packed {
    logic load_item;   // capture accepted item
    logic mul;         // form product and seed divider
    logic axis;        // row or column mapping
    logic div_step;    // one restoring-divide step
    logic div_last;    // final step: store quotient
    logic addr;        // form store address
    logic mem;         // store write or read
    logic out_load;    // load result register
    logic out_fail;    // result is range error
  } dp_cmd_t;

  // datapath -> controller status
  typedef struct packed {
    logic is_read;
    logic req_ok;
    logic map_ok;
    logic out_free;
  } dp_stat_t;

  // quantize: level rounded down to 2^k and clamped to k = 1..7, then
  // (pix >> (8-k)) * (255 / (2^k - 1))
  function automatic logic [PIX_W-1:0] quantize(input logic [PIX_W-1:0] pix,
                                                input logic [LVL_W-1:0] req);
    logic [2:0]         shift;
    logic [PIX_W-1:0]   gain;
    logic [PIX_W-1:0]   lvl_idx;
    logic [2*PIX_W-1:0] prod;
    begin
      if (req >= 9'd128) begin
        shift = 3'd1; gain = 8'd2;
      end else if (req >= 9'd64) begin
        shift = 3'd2; gain = 8'd4;
      end else if (req >= 9'd32) begin
        shift = 3'd3; gain = 8'd8;
      end else if (req >= 9'd16) begin
        shift = 3'd4; gain = 8'd17;
      end else if (req >= 9'd8) begin
        shift = 3'd5; gain = 8'd36;
      end else if (req >= 9'd4) begin
        shift = 3'd6; gain = 8'd85;
      end else begin
        shift = 3'd7; gain = 8'd255;
      end
      lvl_idx = pix >> shift;
      prod    = lvl_idx * gain;
      quantize = prod[PIX_W-1:0];
    end
  endfunction

endpackage

>>> hw/rtl/nsgq_if.sv
// ----------------------------------------------------------------------------
// nsgq_if
// Valid/ready channel interfaces for requests and results.
// ----------------------------------------------------------------------------

// request channel
interface nsgq_in_if;
  logic                      valid;
  logic                      ready;
  logic                      operation;
  logic [nsgq_pkg::DIM_W-1:0] row;
  logic [nsgq_pkg::DIM_W-1:0] col;
  logic [nsgq_pkg::PIX_W-1:0] pixel_in;

  modport source (output valid, operation, row, col, pixel_in, input ready);
  modport sink   (input valid, operation, row, col, pixel_in, output ready);
endinterface

// result channel
interface nsgq_out_if;
  logic                       valid;
  logic                       ready;
  logic [nsgq_pkg::PIX_W-1:0] pixel_out;
  logic [1:0]                 status;

  modport source (output valid, pixel_out, status, input ready);
  modport sink   (input valid, pixel_out, status, output ready);
endinterface

>>> hw/rtl/nsgq_ctrl.sv
// ----------------------------------------------------------------------------
// nsgq_ctrl
// Sequencer: range check, two divides on the shared divider for reads, store access, result hand-off.
// ----------------------------------------------------------------------------
module nsgq_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  nsgq_pkg::dp_stat_t stat,
  output nsgq_pkg::dp_cmd_t  cmd
);

  typedef enum logic [7:0] {
    S_IDLE  = 8'b0000_0001,
    S_CHECK = 8'b0000_0010,
    S_MUL   = 8'b0000_0100,
    S_DIV   = 8'b0000_1000,
    S_ADDR  = 8'b0001_0000,
    S_MEM   = 8'b0010_0000,
    S_DONE  = 8'b0100_0000,
    S_FAIL  = 8'b1000_0000
  } state_t;

  state_t                     state_r, state_nxt;
  logic                       axis_r, axis_nxt;
  logic [nsgq_pkg::CNT_W-1:0] cnt_r, cnt_nxt;
  logic                       div_last;

  assign div_last = (cnt_r == nsgq_pkg::CNT_W'(nsgq_pkg::DIV_STEPS - 1));
  // no item is taken while reset is held
  assign in_ready = (state_r == S_IDLE) && rst_n;

  // next state and command decode
  always_comb begin
    state_nxt = state_r;
    axis_nxt  = axis_r;
    cnt_nxt   = cnt_r;
    cmd       = '0;
    cmd.axis  = axis_r;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load_item = 1'b1;
          state_nxt     = S_CHECK;
        end
      end
      S_CHECK: begin
        axis_nxt = nsgq_pkg::AXIS_ROW;
        if (!stat.req_ok) begin
          state_nxt = S_FAIL;
        end else if (stat.is_read) begin
          state_nxt = S_MUL;
        end else begin
          state_nxt = S_ADDR;
        end
      end
      S_MUL: begin
        cmd.mul   = 1'b1;
        cnt_nxt   = '0;
        state_nxt = S_DIV;
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        cmd.div_last = div_last;
        cnt_nxt      = cnt_r + 1'b1;
        if (div_last) begin
          if (axis_r == nsgq_pkg::AXIS_ROW) begin
            axis_nxt  = nsgq_pkg::AXIS_COL;
            state_nxt = S_MUL;
          end else begin
            state_nxt = S_ADDR;
          end
        end
      end
      S_ADDR: begin
        cmd.addr = 1'b1;
        if (stat.is_read && !stat.map_ok) begin
          state_nxt = S_FAIL;
        end else begin
          state_nxt = S_MEM;
        end
      end
      S_MEM: begin
        cmd.mem   = 1'b1;
        state_nxt = S_DONE;
      end
      S_DONE: begin
        if (stat.out_free) begin
          cmd.out_load = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      S_FAIL: begin
        if (stat.out_free) begin
          cmd.out_load = 1'b1;
          cmd.out_fail = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      axis_r  <= nsgq_pkg::AXIS_ROW;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      axis_r  <= axis_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

endmodule

>>> hw/rtl/nsgq_dp.sv
// ----------------------------------------------------------------------------
// nsgq_dp
// Datapath: config registers, multiplier, restoring divider, frame store,
// quantizer and result register.
// ----------------------------------------------------------------------------
module nsgq_dp (
  input  logic                              clk,
  input  logic                              rst_n,
  // configuration writes
  input  logic                              cfg_we,
  input  logic [nsgq_pkg::CFG_IW-1:0]       cfg_index,
  input  logic [nsgq_pkg::DIM_W-1:0]        cfg_data,
  // request payload
  input  logic                              in_operation,
  input  logic [nsgq_pkg::DIM_W-1:0]        in_row,
  input  logic [nsgq_pkg::DIM_W-1:0]        in_col,
  input  logic [nsgq_pkg::PIX_W-1:0]        in_pixel_in,
  // result
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [nsgq_pkg::PIX_W-1:0]        out_pixel_out,
  output logic [1:0]                        out_status,
  // controller link
  input  nsgq_pkg::dp_cmd_t                 cmd,
  output nsgq_pkg::dp_stat_t                stat
);

  localparam int DW = nsgq_pkg::DIM_W;

  // configuration
  logic [DW-1:0]                src_width_r, src_height_r, dst_width_r, dst_height_r;
  logic [nsgq_pkg::LVL_W-1:0]   gray_levels_r;

  // item
  logic                         op_r;
  logic [DW-1:0]                row_r, col_r;
  logic [nsgq_pkg::PIX_W-1:0]   pix_r;

  // divider
  logic [nsgq_pkg::PROD_W-1:0]  prod;
  logic [DW-1:0]                dvs_r, rem_r, lo_r;
  logic [DW:0]                  trial;
  logic                         qbit;
  logic [DW-1:0]                rem_nxt, lo_nxt;
  logic [DW-1:0]                sr_r, sc_r;

  // store
  logic [nsgq_pkg::STORE_AW-1:0] addr_r, addr_nxt;
  logic [nsgq_pkg::PIX_W-1:0]    mem [nsgq_pkg::STORE_DEPTH];
  logic [nsgq_pkg::PIX_W-1:0]    rdata_r;
  logic [DW-1:0]                 acc_row, acc_col;

  // result
  logic                          out_valid_r;
  logic [nsgq_pkg::PIX_W-1:0]    pixel_r;
  logic [1:0]                    status_r;

  // config registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      src_width_r   <= DW'(512);
      src_height_r  <= DW'(512);
      dst_width_r   <= DW'(384);
      dst_height_r  <= DW'(256);
      gray_levels_r <= nsgq_pkg::LVL_W'(256);
    end else if (cfg_we) begin
      case (nsgq_pkg::cfg_idx_t'(cfg_index))
        nsgq_pkg::CFG_SRC_WIDTH:   src_width_r   <= cfg_data;
        nsgq_pkg::CFG_SRC_HEIGHT:  src_height_r  <= cfg_data;
        nsgq_pkg::CFG_DST_WIDTH:   dst_width_r   <= cfg_data;
        nsgq_pkg::CFG_DST_HEIGHT:  dst_height_r  <= cfg_data;
        nsgq_pkg::CFG_GRAY_LEVELS: gray_levels_r <= cfg_data[nsgq_pkg::LVL_W-1:0];
        default: ;
      endcase
    end
  end

  // item capture
  always_ff @(posedge clk) begin
    if (cmd.load_item) begin
      op_r  <= in_operation;
      row_r <= in_row;
      col_r <= in_col;
      pix_r <= in_pixel_in;
    end
  end

  // range checks
  always_comb begin
    stat.is_read = (op_r == nsgq_pkg::OP_READ);
    if (op_r == nsgq_pkg::OP_READ) begin
      stat.req_ok = (row_r < dst_height_r) && (col_r < dst_width_r) &&
                    (src_width_r != '0) && (src_height_r != '0);
    end else begin
      stat.req_ok = (row_r < src_height_r) && (col_r < src_width_r) &&
                    (32'(row_r) < nsgq_pkg::SRC_HEIGHT_MAX) &&
                    (32'(col_r) < nsgq_pkg::SRC_WIDTH_MAX);
    end
    stat.map_ok   = (32'(sr_r) < nsgq_pkg::SRC_HEIGHT_MAX) &&
                    (32'(sc_r) < nsgq_pkg::SRC_WIDTH_MAX);
    stat.out_free = !out_valid_r || out_ready;
  end

  // product for the selected axis
  assign prod = (cmd.axis == nsgq_pkg::AXIS_COL) ? (col_r * src_width_r)
                                                 : (row_r * src_height_r);

  // one restoring-divide step; remainder stays below divisor
  assign trial   = {rem_r, lo_r[DW-1]};
  assign qbit    = (trial >= {1'b0, dvs_r});
  assign rem_nxt = qbit ? DW'(trial - {1'b0, dvs_r}) : trial[DW-1:0];
  assign lo_nxt  = {lo_r[DW-2:0], qbit};

  // divider registers
  always_ff @(posedge clk) begin
    if (cmd.mul) begin
      rem_r <= prod[2*DW-1:DW];
      lo_r  <= prod[DW-1:0];
      dvs_r <= (cmd.axis == nsgq_pkg::AXIS_COL) ? dst_width_r : dst_height_r;
    end else if (cmd.div_step) begin
      rem_r <= rem_nxt;
      lo_r  <= lo_nxt;
    end
  end

  // mapped coordinates
  always_ff @(posedge clk) begin
    if (cmd.div_step && cmd.div_last) begin
      if (cmd.axis == nsgq_pkg::AXIS_COL) begin
        sc_r <= lo_nxt;
      end else begin
        sr_r <= lo_nxt;
      end
    end
  end

  // store address: row * SRC_WIDTH_MAX + col
  assign acc_row  = (op_r == nsgq_pkg::OP_READ) ? sr_r : row_r;
  assign acc_col  = (op_r == nsgq_pkg::OP_READ) ? sc_r : col_r;
  assign addr_nxt = nsgq_pkg::STORE_AW'(32'(acc_row) * 32'(nsgq_pkg::SRC_WIDTH_MAX) +
                                        32'(acc_col));

  always_ff @(posedge clk) begin
    if (cmd.addr) begin
      addr_r <= addr_nxt;
    end
  end

  // frame store, single port
  always_ff @(posedge clk) begin
    if (cmd.mem) begin
      if (op_r == nsgq_pkg::OP_WRITE) begin
        mem[addr_r] <= pix_r;
      end else begin
        rdata_r <= mem[addr_r];
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      if (cmd.out_fail) begin
        pixel_r  <= '0;
        status_r <= nsgq_pkg::ST_RANGE;
      end else if (op_r == nsgq_pkg::OP_READ) begin
        pixel_r  <= nsgq_pkg::quantize(rdata_r, gray_levels_r);
        status_r <= nsgq_pkg::ST_READ;
      end else begin
        pixel_r  <= '0;
        status_r <= nsgq_pkg::ST_WRITE;
      end
    end
  end

  assign out_valid     = out_valid_r;
  assign out_pixel_out = pixel_r;
  assign out_status    = status_r;

endmodule

>>> hw/rtl/nearest_scale_gray_quantizer_top.sv
// ----------------------------------------------------------------------------
// nearest_scale_gray_quantizer_top
// Nearest-neighbor scaler over a grayscale frame store with gray-level
// quantization of each scaled pixel.
// ----------------------------------------------------------------------------
//  channel  | dir | handshake          | payload
//  in_if    | in  | valid/ready        | operation, row, col, pixel_in
//  out_if   | out | valid/ready        | pixel_out, status
//  cfg_*    | in  | cfg_we (no ready)  | cfg_index, cfg_data
//
//  One item at a time. A read runs check, row seed, a 10-step pass of the
//  shared restoring divider, column seed, a second pass, address, store
//  read, result load. A write skips the seeds and divides; a request out
//  of range fails at the check, a read mapped past the store at address.
//  The next item can be taken in the cycle after the result loads.
//  A finished result sits in the output register; the next item is taken
//  while it waits, and a second result stalls until it leaves.
//  rst_n is synchronous; the frame store is not cleared.
// ----------------------------------------------------------------------------
module nearest_scale_gray_quantizer_top (
  input  logic                        clk,
  input  logic                        rst_n,
  nsgq_in_if.sink                     in_if,
  nsgq_out_if.source                  out_if,
  input  logic                        cfg_we,
  input  logic [nsgq_pkg::CFG_IW-1:0] cfg_index,
  input  logic [nsgq_pkg::DIM_W-1:0]  cfg_data
);

  nsgq_pkg::dp_cmd_t  cmd;
  nsgq_pkg::dp_stat_t stat;
  logic               in_ready;

  assign in_if.ready = in_ready;

  // sequencer
  nsgq_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_if.valid),
    .in_ready (in_ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  // datapath
  nsgq_dp u_dp (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .in_operation  (in_if.operation),
    .in_row        (in_if.row),
    .in_col        (in_if.col),
    .in_pixel_in   (in_if.pixel_in),
    .out_valid     (out_if.valid),
    .out_ready     (out_if.ready),
    .out_pixel_out (out_if.pixel_out),
    .out_status    (out_if.status),
    .cmd           (cmd),
    .stat          (stat)
  );

endmodule

>>> hw/rtl/nsgq_checker.sv
// ----------------------------------------------------------------------------
// nsgq_checker
// Port-level checks on the scaler/quantizer, bound to the top level.
// ----------------------------------------------------------------------------
`include "nearest_scale_gray_quantizer_top_assert.svh"

module nsgq_checker (
  input logic                       clk,
  input logic                       rst_n,
  input logic                       in_valid,
  input logic                       in_ready,
  input logic                       out_valid,
  input logic                       out_ready,
  input logic [nsgq_pkg::PIX_W-1:0] pixel_out,
  input logic [1:0]                 status
);

  // only defined status codes leave the block
  `NSGQ_ASSERT_SAME(a_status_code, clk, rst_n, out_valid, (status == nsgq_pkg::ST_READ) || (status == nsgq_pkg::ST_WRITE) || (status == nsgq_pkg::ST_RANGE), "undefined status code")

  // writes and range errors carry a zero pixel
  `NSGQ_ASSERT_SAME(a_zero_pixel, clk, rst_n, out_valid && (status != nsgq_pkg::ST_READ), pixel_out == '0, "nonzero pixel on non-read result")

  // one item at a time: no accept right after an accept
  `NSGQ_ASSERT_NEXT(a_one_item, clk, rst_n, in_valid && in_ready, !in_ready, "request taken while busy")

  // stalled result holds
  `NSGQ_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable(pixel_out) && $stable(status), "result changed under stall")

endmodule

bind nearest_scale_gray_quantizer_top nsgq_checker u_nsgq_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_if.valid),
  .in_ready  (in_if.ready),
  .out_valid (out_if.valid),
  .out_ready (out_if.ready),
  .pixel_out (out_if.pixel_out),
  .status    (out_if.status)
);

>>> test/nearest_scale_gray_quantizer_top_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nearest_scale_gray_quantizer_top_tb
// Self-checking bench for the scaler/quantizer. It loads source pixels, then
// issues scaled reads under a series of register settings. Every result is
// predicted when its item is accepted and compared in order, field by field.
// ----------------------------------------------------------------------------
module nearest_scale_gray_quantizer_top_tb;

  localparam int PHASES       = 12;
  localparam int PHASE_ITEMS  = 150;
  localparam int LONG_HOLD    = 400;     // receiver hold-off, in cycles
  localparam int DRAIN_CYCLES = 40;      // idle time after the last result, in cycles
  localparam int CYCLE_LIMIT  = 1000000;
  localparam int MAX_PRINTS   = 40;

  // one result item
  typedef struct {
    logic [nsgq_pkg::PIX_W-1:0] pixel_out;
    logic [1:0]                 status;
  } scaled_px_t;

  // one register setting
  typedef struct {
    int unsigned src_w;
    int unsigned src_h;
    int unsigned dst_w;
    int unsigned dst_h;
    int unsigned levels;
  } phase_cfg_t;

  // --------------------------------------------------------------------------
  // Scoreboard: mirrors registers and frame store, queues expected results
  // --------------------------------------------------------------------------
  class scaled_pixel_scoreboard;
    int unsigned                src_w, src_h, dst_w, dst_h, levels;
    logic [nsgq_pkg::PIX_W-1:0] frame [int unsigned];
    scaled_px_t                 expected_q [$];
    int                         mismatches;

    function new();
      src_w      = 512;
      src_h      = 512;
      dst_w      = 384;
      dst_h      = 256;
      levels     = 256;
      mismatches = 0;
    endfunction

    function void set_reg(nsgq_pkg::cfg_idx_t idx, int unsigned val);
      case (idx)
        nsgq_pkg::CFG_SRC_WIDTH:   src_w  = 32'(val[nsgq_pkg::DIM_W-1:0]);
        nsgq_pkg::CFG_SRC_HEIGHT:  src_h  = 32'(val[nsgq_pkg::DIM_W-1:0]);
        nsgq_pkg::CFG_DST_WIDTH:   dst_w  = 32'(val[nsgq_pkg::DIM_W-1:0]);
        nsgq_pkg::CFG_DST_HEIGHT:  dst_h  = 32'(val[nsgq_pkg::DIM_W-1:0]);
        nsgq_pkg::CFG_GRAY_LEVELS: levels = 32'(val[nsgq_pkg::LVL_W-1:0]);
        default: ;
      endcase
    endfunction

    // output pixel -> store address of its nearest source pixel
    function bit map_read(logic [nsgq_pkg::DIM_W-1:0] row, logic [nsgq_pkg::DIM_W-1:0] col,
                          output int unsigned addr);
      int unsigned sr, sc;
      addr = 0;
      if (row >= dst_h || col >= dst_w || src_w == 0 || src_h == 0) return 1'b0;
      sr = (row * src_h) / dst_h;
      sc = (col * src_w) / dst_w;
      if (sr >= nsgq_pkg::SRC_HEIGHT_MAX || sc >= nsgq_pkg::SRC_WIDTH_MAX) return 1'b0;
      addr = sr * nsgq_pkg::SRC_WIDTH_MAX + sc;
      return 1'b1;
    endfunction

    // level count rounded down to a power of two, clamped to 2..128
    function logic [nsgq_pkg::PIX_W-1:0] gray_map(logic [nsgq_pkg::PIX_W-1:0] v);
      int unsigned lv, q;
      lv = 2;
      for (int k = 2; k <= 7; k++) begin
        if (levels >= (32'd1 << k)) lv = 32'd1 << k;
      end
      q = (v / (256 / lv)) * (255 / (lv - 1));
      return q[nsgq_pkg::PIX_W-1:0];
    endfunction

    function void note_request(logic op, logic [nsgq_pkg::DIM_W-1:0] row,
                               logic [nsgq_pkg::DIM_W-1:0] col,
                               logic [nsgq_pkg::PIX_W-1:0] pix);
      scaled_px_t  r;
      int unsigned addr;
      r.pixel_out = '0;
      r.status    = nsgq_pkg::ST_RANGE;
      if (op == nsgq_pkg::OP_WRITE) begin
        if (row < src_h && col < src_w &&
            row < nsgq_pkg::SRC_HEIGHT_MAX && col < nsgq_pkg::SRC_WIDTH_MAX) begin
          addr        = row * nsgq_pkg::SRC_WIDTH_MAX + col;
          frame[addr] = pix;
          r.status    = nsgq_pkg::ST_WRITE;
        end
      end else if (map_read(row, col, addr)) begin
        r.pixel_out = frame.exists(addr) ? gray_map(frame[addr]) : '0;
        r.status    = nsgq_pkg::ST_READ;
      end
      expected_q.push_back(r);
    endfunction

    task report(string msg);
      mismatches++;
      if (mismatches <= MAX_PRINTS) $display("[%0t] mismatch: %s", $time, msg);
    endtask

    task check_result(logic [nsgq_pkg::PIX_W-1:0] pix, logic [1:0] st);
      scaled_px_t want;
      if (expected_q.size() == 0) begin
        report($sformatf("result with nothing pending (pixel %0d status %0d)", pix, st));
        return;
      end
      want = expected_q.pop_front();
      if (st !== want.status)
        report($sformatf("status %0d, expected %0d", st, want.status));
      if (pix !== want.pixel_out)
        report($sformatf("pixel_out %0d, expected %0d", pix, want.pixel_out));
    endtask
  endclass

  // --------------------------------------------------------------------------
  // DUT and channels
  // --------------------------------------------------------------------------
  logic                       clk;
  logic                       rst_n;
  logic                       cfg_we;
  nsgq_pkg::cfg_idx_t         cfg_index;
  logic [nsgq_pkg::DIM_W-1:0] cfg_data;

  nsgq_in_if  in_ch ();
  nsgq_out_if out_ch ();

  nearest_scale_gray_quantizer_top u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_if     (in_ch),
    .out_if    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  scaled_pixel_scoreboard board;
  bit                     pixels_loaded [int unsigned];  // writes already issued
  bit                     calm     = 1'b0;
  bit                     hold_req = 1'b0;
  int unsigned            cycle_count = 0;
  int unsigned            items_sent  = 0;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // --------------------------------------------------------------------------
  // Stimulus tasks
  // --------------------------------------------------------------------------
  task automatic send_item(logic op, int unsigned row, int unsigned col, int unsigned pix);
    // random sender gap
    if (!calm && $urandom_range(0, 4) == 0) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk);
    end
    in_ch.valid     <= 1'b1;
    in_ch.operation <= op;
    in_ch.row       <= row[nsgq_pkg::DIM_W-1:0];
    in_ch.col       <= col[nsgq_pkg::DIM_W-1:0];
    in_ch.pixel_in  <= pix[nsgq_pkg::PIX_W-1:0];
    if (op == nsgq_pkg::OP_WRITE && row < board.src_h && col < board.src_w &&
        row < nsgq_pkg::SRC_HEIGHT_MAX && col < nsgq_pkg::SRC_WIDTH_MAX)
      pixels_loaded[row * nsgq_pkg::SRC_WIDTH_MAX + col] = 1'b1;
    items_sent++;
    do @(posedge clk); while (in_ch.ready !== 1'b1);
  endtask

  // a read whose source pixel was never loaded gets a write in front of it
  task automatic request_read(int unsigned row, int unsigned col);
    int unsigned addr;
    if (board.map_read(row[nsgq_pkg::DIM_W-1:0], col[nsgq_pkg::DIM_W-1:0], addr) &&
        !pixels_loaded.exists(addr))
      send_item(nsgq_pkg::OP_WRITE, addr / nsgq_pkg::SRC_WIDTH_MAX,
                addr % nsgq_pkg::SRC_WIDTH_MAX, $urandom_range(0, 255));
    send_item(nsgq_pkg::OP_READ, row, col, $urandom_range(0, 255));
  endtask

  // stop offering and wait for every pending result
  task automatic wait_drained();
    in_ch.valid <= 1'b0;
    @(negedge clk);
    while (board.expected_q.size() != 0) @(negedge clk);
    @(posedge clk);
  endtask

  task automatic write_reg(nsgq_pkg::cfg_idx_t idx, int unsigned val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val[nsgq_pkg::DIM_W-1:0];
    board.set_reg(idx, val);
    @(posedge clk);
  endtask

  task automatic load_config(phase_cfg_t pc);
    write_reg(nsgq_pkg::CFG_SRC_WIDTH, pc.src_w);
    write_reg(nsgq_pkg::CFG_SRC_HEIGHT, pc.src_h);
    write_reg(nsgq_pkg::CFG_DST_WIDTH, pc.dst_w);
    write_reg(nsgq_pkg::CFG_DST_HEIGHT, pc.dst_h);
    write_reg(nsgq_pkg::CFG_GRAY_LEVELS, pc.levels);
    cfg_we <= 1'b0;
  endtask

  function automatic phase_cfg_t pick_phase(int p);
    phase_cfg_t  pc;
    int          band;
    int unsigned lo, hi;
    case (p)
      0: pc = '{1, 1, 1023, 1023, 0};        // tiny source, huge output, 2 levels
      1: pc = '{512, 512, 1, 1, 256};        // full source, 1x1 output
      2: pc = '{512, 512, 1023, 1023, 1};    // upscale, level 1 rounds to 2
      3: pc = '{7, 5, 3, 2, 3};              // downscale, level 3 rounds to 2
      default: begin
        pc.src_w = ($urandom_range(0, 4) == 0) ? $urandom_range(1, 512) : $urandom_range(1, 24);
        pc.src_h = ($urandom_range(0, 4) == 0) ? $urandom_range(1, 512) : $urandom_range(1, 24);
        pc.dst_w = $urandom_range(0, 1) ? $urandom_range(1, 1023) : $urandom_range(1, 64);
        pc.dst_h = $urandom_range(0, 1) ? $urandom_range(1, 1023) : $urandom_range(1, 64);
        // walk through the rounding bands of the level register
        band      = p % 7;
        lo        = (band == 0) ? 0 : (32'd1 << (band + 1));
        hi        = (band == 6) ? 256 : (32'd1 << (band + 2)) - 1;
        pc.levels = $urandom_range(lo, hi);
      end
    endcase
    return pc;
  endfunction

  // directed items at the reset setting (512x512 source, 384x256 output)
  task automatic run_directed();
    send_item(nsgq_pkg::OP_WRITE, 0, 0, 8'hFF);
    send_item(nsgq_pkg::OP_WRITE, 511, 511, 8'h00);
    send_item(nsgq_pkg::OP_WRITE, 510, 510, 8'h55);
    send_item(nsgq_pkg::OP_WRITE, 0, 511, 8'hAA);
    send_item(nsgq_pkg::OP_WRITE, 512, 0, 8'h12);      // row past source height
    send_item(nsgq_pkg::OP_WRITE, 0, 512, 8'h34);      // col past source width
    send_item(nsgq_pkg::OP_WRITE, 1023, 1023, 8'hFF);
    request_read(0, 0);
    request_read(255, 383);                  // maps to source (510, 510)
    request_read(0, 383);
    request_read(255, 0);
    request_read(256, 0);                    // row past output height
    request_read(0, 384);                    // col past output width
    request_read(1023, 1023);
    request_read(255, 384);
  endtask

  // each phase sends at least PHASE_ITEMS items, loads and pre-writes included
  task automatic run_phase(int p, phase_cfg_t pc);
    int unsigned pick;
    int unsigned start_cnt;
    int          k;
    start_cnt = items_sent;
    k         = 0;
    // well-formed start: load a small source image completely
    if (pc.src_w * pc.src_h <= 64) begin
      for (int r = 0; r < pc.src_h; r++)
        for (int c = 0; c < pc.src_w; c++)
          send_item(nsgq_pkg::OP_WRITE, r, c, $urandom_range(0, 255));
    end
    while (items_sent - start_cnt < PHASE_ITEMS) begin
      // long receiver hold-off while items keep coming
      if (p == 4 && k == 20) hold_req <= 1'b1;
      // sender pause until everything is back
      if (p == 5 && k == 10) wait_drained();
      pick = $urandom_range(0, 99);
      if (pick < 60)
        request_read($urandom_range(0, pc.dst_h - 1), $urandom_range(0, pc.dst_w - 1));
      else if (pick < 70)
        request_read($urandom_range(0, 1023), $urandom_range(0, 1023));
      else if (pick < 90)
        send_item(nsgq_pkg::OP_WRITE, $urandom_range(0, pc.src_h - 1),
                  $urandom_range(0, pc.src_w - 1), $urandom_range(0, 255));
      else
        send_item(nsgq_pkg::OP_WRITE, $urandom_range(0, 1023), $urandom_range(0, 1023),
                  $urandom_range(0, 255));
      k++;
    end
  endtask

  // --------------------------------------------------------------------------
  // Main sequence
  // --------------------------------------------------------------------------
  initial begin
    phase_cfg_t pc;
    board           = new();
    rst_n           <= 1'b0;
    in_ch.valid     <= 1'b0;
    in_ch.operation <= nsgq_pkg::OP_WRITE;
    in_ch.row       <= '0;
    in_ch.col       <= '0;
    in_ch.pixel_in  <= '0;
    cfg_we          <= 1'b0;
    cfg_index       <= nsgq_pkg::CFG_SRC_WIDTH;
    cfg_data        <= '0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    run_directed();
    for (int p = 0; p < PHASES; p++) begin
      pc = pick_phase(p);
      wait_drained();
      load_config(pc);
      calm <= (p == PHASES - 1);
      run_phase(p, pc);
    end

    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (board.mismatches == 0 && board.expected_q.size() == 0)
      $display("Regression PASS");
    else
      $display("Regression FAIL");
    $finish;
  end

  // result receiver: random stalls plus one long hold-off
  initial begin : result_sink
    int stall;
    stall = 0;
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req) begin
        hold_req <= 1'b0;
        stall = LONG_HOLD;
      end else if (stall == 0 && !calm && $urandom_range(0, 4) == 0) begin
        stall = $urandom_range(1, 8);
      end
      if (stall > 0) begin
        out_ch.ready <= 1'b0;
        stall--;
      end else begin
        out_ch.ready <= 1'b1;
      end
    end
  end

  // monitors: predict on input accept, check on output accept
  always @(posedge clk) begin
    if (rst_n === 1'b1 && in_ch.valid === 1'b1 && in_ch.ready === 1'b1)
      board.note_request(in_ch.operation, in_ch.row, in_ch.col, in_ch.pixel_in);
    if (rst_n === 1'b1 && out_ch.valid === 1'b1 && out_ch.ready === 1'b1)
      board.check_result(out_ch.pixel_out, out_ch.status);
  end

  // watchdog
  initial begin : watchdog
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("Regression FAIL");
    $finish;
  end

endmodule
